// ===== rtl/jgs_pkg.sv =====
// Shared types and constants of the Jacobi grid sweep block.
package jgs_pkg;

    localparam int DATA_W    = 16;
    localparam int SUM_W     = 28;
    localparam int ROWCOL_W  = 6;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SWEEP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_LEFT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_RIGHT  = 2'd3;

    // Largest value the change sum can hold.
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic [DATA_W-1:0] edge_top;
        logic [DATA_W-1:0] edge_bottom;
        logic [DATA_W-1:0] edge_left;
        logic [DATA_W-1:0] edge_right;
    } jgs_edges_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] sum;
    } jgs_sweep_stat_t;

endpackage

// ===== rtl/jacobi_grid_sweep.sv =====
// Top level of the Jacobi grid sweep block: control, banks, configuration and result register.
//
//  Channel  Direction  Handshake           Payload
//  -------  ---------  ------------------  ----------------------------------------
//  s_       in         s_valid / s_ready   s_kind, s_row, s_col, s_cell_value
//  m_       out        m_valid / m_ready   m_read_value, m_change_sum
//  cfg_     in         cfg_we              cfg_index, cfg_wdata
//
//  After reset a clearing pass zeroes both banks, one entry of each per cycle; no item
//  is accepted during that time. A write item (and the unused kind) goes straight to
//  the delivery step, and a read item first passes the read step, where the bank output
//  is taken; from the delivery step the result enters the output register.
//  A sweep streams one cell per cycle through the bank read ports and its pipeline,
//  and its result is delivered once the engine reports completion.
//  One item is worked on at a time; the next item is accepted once the block is back
//  in idle after the result has entered the output register. A finished result waits
//  there while the next item is accepted; a stalled output holds only the delivery step.
module jacobi_grid_sweep #(
    parameter int GRID_SIZE = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input item channel.
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [jgs_pkg::KIND_W-1:0]         s_kind,
    input  logic [jgs_pkg::ROWCOL_W-1:0]       s_row,
    input  logic [jgs_pkg::ROWCOL_W-1:0]       s_col,
    input  logic signed [jgs_pkg::DATA_W-1:0]  s_cell_value,
    // Result item channel.
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [jgs_pkg::DATA_W-1:0]  m_read_value,
    output logic [jgs_pkg::SUM_W-1:0]          m_change_sum,
    // Configuration write port.
    input  logic                               cfg_we,
    input  logic [jgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jgs_pkg::DATA_W-1:0]         cfg_wdata
);
    import jgs_pkg::*;

    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR   = 5'b00001,
        ST_IDLE    = 5'b00010,
        ST_READ    = 5'b00100,
        ST_SWEEP   = 5'b01000,
        ST_DELIVER = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [AW-1:0]     clr_cnt_reg;
    logic              active_reg;      // zero: bank a is current
    jgs_edges_t        edges_reg;

    // Result waiting for the output register, and the output register itself.
    logic [DATA_W-1:0] res_read_reg;
    logic [SUM_W-1:0]  res_change_reg;
    logic              inside_reg;
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_read_value_reg;
    logic [SUM_W-1:0]  m_change_sum_reg;

    logic              accept;
    logic              out_free;
    logic              item_inside;
    logic [31:0]       item_lin;
    logic [AW-1:0]     item_addr;
    logic              item_we;
    logic              sweep_start;

    logic              we_a;
    logic              we_b;
    logic [AW-1:0]     bank_waddr;
    logic [DATA_W-1:0] bank_wdata;
    logic [AW-1:0]     bank_raddr0;
    logic [AW-1:0]     bank_raddr1;
    logic [DATA_W-1:0] a_rd0;
    logic [DATA_W-1:0] a_rd1;
    logic [DATA_W-1:0] b_rd0;
    logic [DATA_W-1:0] b_rd1;
    logic [DATA_W-1:0] cur_rd0;
    logic [DATA_W-1:0] cur_rd1;

    logic [AW-1:0]     sw_rd0_addr;
    logic [AW-1:0]     sw_rd1_addr;
    logic              sw_wr_en;
    logic [AW-1:0]     sw_wr_addr;
    logic [DATA_W-1:0] sw_wr_data;
    jgs_sweep_stat_t   sw_stat;

    // Items are taken only between pieces of work; the output register keeps the
    // previous result meanwhile.
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Row and column come in six bits; cells outside a smaller grid are rejected.
    assign item_inside = (32'(s_row) < 32'(GRID_SIZE)) && (32'(s_col) < 32'(GRID_SIZE));
    assign item_lin    = 32'(s_row) * 32'(GRID_SIZE) + 32'(s_col);
    assign item_addr   = item_lin[AW-1:0];
    assign item_we     = accept && (s_kind == KIND_WRITE) && item_inside;
    assign sweep_start = accept && (s_kind == KIND_SWEEP);

    // Both banks share addresses and write data. Item writes go to the current bank,
    // sweep results to the other one, and the clearing pass writes both.
    always_comb begin
        bank_raddr0 = (state_reg == ST_SWEEP) ? sw_rd0_addr : item_addr;
        bank_raddr1 = sw_rd1_addr;
        if (state_reg == ST_CLEAR) begin
            bank_waddr = clr_cnt_reg;
            bank_wdata = '0;
        end else if (state_reg == ST_SWEEP) begin
            bank_waddr = sw_wr_addr;
            bank_wdata = sw_wr_data;
        end else begin
            bank_waddr = item_addr;
            bank_wdata = s_cell_value;
        end
        we_a = (state_reg == ST_CLEAR) || (item_we && !active_reg) || (sw_wr_en && active_reg);
        we_b = (state_reg == ST_CLEAR) || (item_we && active_reg) || (sw_wr_en && !active_reg);
    end

    jgs_bank #(
        .DEPTH(CELLS)
    ) u_bank_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (bank_waddr),
        .wdata (bank_wdata),
        .raddr0(bank_raddr0),
        .raddr1(bank_raddr1),
        .rdata0(a_rd0),
        .rdata1(a_rd1)
    );

    jgs_bank #(
        .DEPTH(CELLS)
    ) u_bank_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (bank_waddr),
        .wdata (bank_wdata),
        .raddr0(bank_raddr0),
        .raddr1(bank_raddr1),
        .rdata0(b_rd0),
        .rdata1(b_rd1)
    );

    assign cur_rd0 = active_reg ? b_rd0 : a_rd0;
    assign cur_rd1 = active_reg ? b_rd1 : a_rd1;

    jgs_sweep #(
        .GRID_SIZE(GRID_SIZE)
    ) u_sweep (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sweep_start),
        .edges   (edges_reg),
        .rd0_data(cur_rd0),
        .rd1_data(cur_rd1),
        .rd0_addr(sw_rd0_addr),
        .rd1_addr(sw_rd1_addr),
        .wr_en   (sw_wr_en),
        .wr_addr (sw_wr_addr),
        .wr_data (sw_wr_data),
        .stat    (sw_stat)
    );

    // Edge value registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edges_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_EDGE_TOP:    edges_reg.edge_top    <= cfg_wdata;
                CFG_EDGE_BOTTOM: edges_reg.edge_bottom <= cfg_wdata;
                CFG_EDGE_LEFT:   edges_reg.edge_left   <= cfg_wdata;
                CFG_EDGE_RIGHT:  edges_reg.edge_right  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == LAST_CELL) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (s_kind)
                        KIND_SWEEP: state_next = ST_SWEEP;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_DELIVER;
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_DELIVER;
            end
            ST_SWEEP: begin
                if (sw_stat.done) begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            active_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            // The new grid becomes current once its last cell has been written.
            if (state_reg == ST_SWEEP && sw_stat.done) begin
                active_reg <= !active_reg;
            end
        end
    end

    // Result of the item at work. Writes and the unused kind report all zero.
    always_ff @(posedge aclk) begin
        if (accept) begin
            inside_reg     <= item_inside;
            res_read_reg   <= '0;
            res_change_reg <= '0;
        end else if (state_reg == ST_READ) begin
            res_read_reg <= inside_reg ? cur_rd0 : '0;
        end else if (state_reg == ST_SWEEP && sw_stat.done) begin
            res_change_reg <= sw_stat.sum;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DELIVER && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DELIVER && out_free) begin
            m_read_value_reg <= res_read_reg;
            m_change_sum_reg <= res_change_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_read_value_reg;
    assign m_change_sum = m_change_sum_reg;

    // The current bank changes only when a sweep has finished.
    a_bank_select: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg == ST_SWEEP && sw_stat.done) |=> $stable(active_reg))
        else $error("current bank changed outside the end of a sweep");

    // The sweep engine reports completion only while a sweep item is at work.
    a_done_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        sw_stat.done |-> (state_reg == ST_SWEEP))
        else $error("sweep completion outside a sweep");

    // A finished result enters the output register and the block returns to idle.
    a_deliver: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DELIVER && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("result not delivered to the output register");

    // The clearing pass ends after its last entry.
    a_clear_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && clr_cnt_reg == LAST_CELL) |=> (state_reg == ST_IDLE))
        else $error("clearing pass did not end at the last entry");

endmodule

// ===== rtl/jgs_bank.sv =====
// One grid bank: synchronous memory with one write port and two registered read ports.
module jgs_bank #(
    parameter int DEPTH = 4096
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [jgs_pkg::DATA_W-1:0]       wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr0,
    input  logic [$clog2(DEPTH)-1:0]         raddr1,
    output logic [jgs_pkg::DATA_W-1:0]       rdata0,
    output logic [jgs_pkg::DATA_W-1:0]       rdata1
);
    import jgs_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata0_reg;
    logic [DATA_W-1:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ===== rtl/jgs_sweep.sv =====
// Sweep engine: raster read stream, row line buffer, stencil and change accumulation.
module jgs_sweep #(
    parameter int GRID_SIZE = 64
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        start,
    input  jgs_pkg::jgs_edges_t                         edges,
    input  logic [jgs_pkg::DATA_W-1:0]                  rd0_data,
    input  logic [jgs_pkg::DATA_W-1:0]                  rd1_data,
    output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]      rd0_addr,
    output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]      rd1_addr,
    output logic                                        wr_en,
    output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]      wr_addr,
    output logic [jgs_pkg::DATA_W-1:0]                  wr_data,
    output jgs_pkg::jgs_sweep_stat_t                    stat
);
    import jgs_pkg::*;

    localparam int CELLS = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_SIZE);
    localparam logic [RW-1:0] LAST_IDX = RW'(GRID_SIZE - 1);
    localparam logic [AW-1:0] ROW_STEP = AW'(GRID_SIZE);

    // Issue stage: cell whose center and lower neighbor are read this cycle.
    logic          iss_active_reg;
    logic          iss_flush_reg;
    logic [RW-1:0] iss_row_reg;
    logic [RW-1:0] iss_col_reg;
    logic [AW-1:0] iss_addr_reg;

    // Arrival stage: read data of the issued cell is on the memory outputs.
    logic          s1_valid_reg;
    logic          s1_flush_reg;
    logic [RW-1:0] s1_row_reg;
    logic [RW-1:0] s1_col_reg;
    logic [AW-1:0] s1_addr_reg;

    // Line buffer holding the centers of the previous row.
    logic [DATA_W-1:0] lb_mem [GRID_SIZE];
    logic [DATA_W-1:0] lb_q_reg;

    // Window: the cell being finished and the center to its left.
    logic              h_valid_reg;
    logic [RW-1:0]     h_col_reg;
    logic [AW-1:0]     h_addr_reg;
    logic [DATA_W-1:0] h_cen_reg;
    logic [DATA_W-1:0] h_up_reg;
    logic [DATA_W-1:0] h_dn_reg;
    logic [DATA_W-1:0] h_left_reg;

    // Write-back stage.
    logic              w_valid_reg;
    logic              w_last_reg;
    logic [AW-1:0]     w_addr_reg;
    logic [DATA_W-1:0] w_data_reg;
    logic [DATA_W-1:0] w_old_reg;

    // Accumulation stage.
    logic              d_valid_reg;
    logic              d_last_reg;
    logic [DATA_W:0]   d_abs_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic              done_reg;

    logic [DATA_W-1:0] cen;
    logic [DATA_W-1:0] up;
    logic [DATA_W-1:0] dn;
    logic [DATA_W-1:0] left_nb;
    logic [DATA_W-1:0] right_nb;
    logic [DATA_W+1:0] nb_sum;
    logic [DATA_W:0]   diff;
    logic [DATA_W:0]   diff_abs;
    logic [SUM_W:0]    acc_sum;

    assign rd0_addr = iss_addr_reg;
    assign rd1_addr = (iss_row_reg == LAST_IDX) ? iss_addr_reg : iss_addr_reg + ROW_STEP;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_active_reg <= 1'b0;
            iss_flush_reg  <= 1'b0;
        end else if (start) begin
            iss_active_reg <= 1'b1;
            iss_flush_reg  <= 1'b0;
        end else if (iss_active_reg) begin
            if (iss_flush_reg) begin
                iss_active_reg <= 1'b0;
            end else if (iss_row_reg == LAST_IDX && iss_col_reg == LAST_IDX) begin
                iss_flush_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            iss_row_reg  <= '0;
            iss_col_reg  <= '0;
            iss_addr_reg <= '0;
        end else if (iss_active_reg && !iss_flush_reg
                     && !(iss_row_reg == LAST_IDX && iss_col_reg == LAST_IDX)) begin
            iss_addr_reg <= iss_addr_reg + AW'(1);
            if (iss_col_reg == LAST_IDX) begin
                iss_col_reg <= '0;
                iss_row_reg <= iss_row_reg + RW'(1);
            end else begin
                iss_col_reg <= iss_col_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= iss_active_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_flush_reg <= iss_flush_reg;
        s1_row_reg   <= iss_row_reg;
        s1_col_reg   <= iss_col_reg;
        s1_addr_reg  <= iss_addr_reg;
    end

    // The previous row's center at this column is read as the upper neighbor,
    // then overwritten by this row's center when it arrives.
    always_ff @(posedge aclk) begin
        lb_q_reg <= lb_mem[iss_col_reg];
        if (s1_valid_reg && !s1_flush_reg) begin
            lb_mem[s1_col_reg] <= rd0_data;
        end
    end

    assign cen = rd0_data;
    assign dn  = (s1_row_reg == LAST_IDX) ? edges.edge_bottom : rd1_data;
    assign up  = (s1_row_reg == '0) ? edges.edge_top : lb_q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else if (start) begin
            h_valid_reg <= 1'b0;
        end else if (s1_valid_reg) begin
            h_valid_reg <= !s1_flush_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            h_left_reg <= h_cen_reg;
            h_cen_reg  <= cen;
            h_up_reg   <= up;
            h_dn_reg   <= dn;
            h_col_reg  <= s1_col_reg;
            h_addr_reg <= s1_addr_reg;
        end
    end

    // The held cell is finished once its right neighbor has arrived.
    assign left_nb  = (h_col_reg == '0) ? edges.edge_left : h_left_reg;
    assign right_nb = (h_col_reg == LAST_IDX) ? edges.edge_right : cen;
    assign nb_sum   = {{2{h_up_reg[DATA_W-1]}}, h_up_reg}
                    + {{2{h_dn_reg[DATA_W-1]}}, h_dn_reg}
                    + {{2{left_nb[DATA_W-1]}}, left_nb}
                    + {{2{right_nb[DATA_W-1]}}, right_nb};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_valid_reg <= 1'b0;
        end else begin
            w_valid_reg <= s1_valid_reg && h_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        w_last_reg <= s1_flush_reg;
        w_addr_reg <= h_addr_reg;
        w_data_reg <= nb_sum[DATA_W+1:2];
        w_old_reg  <= h_cen_reg;
    end

    assign wr_en   = w_valid_reg;
    assign wr_addr = w_addr_reg;
    assign wr_data = w_data_reg;

    assign diff     = {w_data_reg[DATA_W-1], w_data_reg} - {w_old_reg[DATA_W-1], w_old_reg};
    assign diff_abs = diff[DATA_W] ? (~diff + (DATA_W+1)'(1)) : diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            d_last_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            d_valid_reg <= w_valid_reg;
            d_last_reg  <= w_valid_reg && w_last_reg;
            done_reg    <= d_valid_reg && d_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        d_abs_reg <= diff_abs;
    end

    assign acc_sum = {1'b0, acc_reg} + (SUM_W+1)'(d_abs_reg);

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
        end else if (d_valid_reg) begin
            acc_reg <= acc_sum[SUM_W] ? SUM_MAX : acc_sum[SUM_W-1:0];
        end
    end

    assign stat.done = done_reg;
    assign stat.sum  = acc_reg;

endmodule

// ===== verif/jacobi_grid_sweep_checker.sv =====
`timescale 1ns / 100ps
// Checker for the Jacobi grid sweep block: grid predictor and per-item result comparison.
module jacobi_grid_sweep_checker #(
    parameter int GRID_SIZE = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [jgs_pkg::KIND_W-1:0]         s_kind,
    input  logic [jgs_pkg::ROWCOL_W-1:0]       s_row,
    input  logic [jgs_pkg::ROWCOL_W-1:0]       s_col,
    input  logic signed [jgs_pkg::DATA_W-1:0]  s_cell_value,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic signed [jgs_pkg::DATA_W-1:0]  m_read_value,
    input  logic [jgs_pkg::SUM_W-1:0]          m_change_sum,
    input  logic                               cfg_we,
    input  logic [jgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jgs_pkg::DATA_W-1:0]         cfg_wdata,
    output int                                 failures,
    output int                                 outstanding
);
    import jgs_pkg::*;

    localparam int CELLS     = GRID_SIZE * GRID_SIZE;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        logic [SUM_W-1:0]         change_sum;
    } grid_result_t;

    // Two banks; cur_bank names the one that reads and writes address.
    logic signed [DATA_W-1:0] cells [2][CELLS];
    logic                     cur_bank;
    logic signed [DATA_W-1:0] edge_up, edge_down, edge_lft, edge_rgt;
    grid_result_t             results_due [$];
    int                       delivered;

    // One full sweep into the other bank, then swap banks.
    function automatic logic [SUM_W-1:0] sweep_grid();
        int     up, down, lft, rgt, old_v, new_v, delta, idx;
        longint total;
        logic   nxt;
        total = 0;
        nxt   = ~cur_bank;
        for (int r = 0; r < GRID_SIZE; r++) begin
            for (int c = 0; c < GRID_SIZE; c++) begin
                idx   = r * GRID_SIZE + c;
                up    = (r == 0) ? edge_up : cells[cur_bank][idx - GRID_SIZE];
                down  = (r == GRID_SIZE - 1) ? edge_down : cells[cur_bank][idx + GRID_SIZE];
                lft   = (c == 0) ? edge_lft : cells[cur_bank][idx - 1];
                rgt   = (c == GRID_SIZE - 1) ? edge_rgt : cells[cur_bank][idx + 1];
                old_v = cells[cur_bank][idx];
                // Arithmetic shift on a signed int floors toward minus infinity.
                new_v = (up + down + lft + rgt) >>> 2;
                delta = (new_v > old_v) ? new_v - old_v : old_v - new_v;
                cells[nxt][idx] = DATA_W'(new_v);
                total += delta;
                if (total > SUM_MAX)
                    total = SUM_MAX;
            end
        end
        cur_bank = nxt;
        return SUM_W'(total);
    endfunction

    function automatic grid_result_t predict_item(
        input logic [KIND_W-1:0]       k,
        input logic [ROWCOL_W-1:0]     r,
        input logic [ROWCOL_W-1:0]     c,
        input logic signed [DATA_W-1:0] v
    );
        grid_result_t res;
        logic         in_grid;
        int           idx;
        res.read_value = '0;
        res.change_sum = '0;
        in_grid = (int'(r) < GRID_SIZE) && (int'(c) < GRID_SIZE);
        idx = int'(r) * GRID_SIZE + int'(c);
        case (k)
            KIND_WRITE: begin
                if (in_grid)
                    cells[cur_bank][idx] = v;
            end
            KIND_SWEEP: begin
                res.change_sum = sweep_grid();
            end
            KIND_READ: begin
                if (in_grid)
                    res.read_value = cells[cur_bank][idx];
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_SHOWN)
            $display("jacobi_grid_sweep_checker: %s", msg);
    endtask

    always @(posedge aclk) begin
        grid_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < CELLS; i++) begin
                cells[0][i] = '0;
                cells[1][i] = '0;
            end
            cur_bank  = 1'b0;
            edge_up   = '0;
            edge_down = '0;
            edge_lft  = '0;
            edge_rgt  = '0;
            results_due.delete();
            failures  = 0;
            delivered = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_EDGE_TOP:    edge_up   = cfg_wdata;
                    CFG_EDGE_BOTTOM: edge_down = cfg_wdata;
                    CFG_EDGE_LEFT:   edge_lft  = cfg_wdata;
                    CFG_EDGE_RIGHT:  edge_rgt  = cfg_wdata;
                    default: begin
                    end
                endcase
            end
            // A result is always older than any item accepted at the same edge.
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with nothing expected",
                                           delivered));
                end else begin
                    want = results_due.pop_front();
                    if (want.read_value !== m_read_value || want.change_sum !== m_change_sum)
                        note_failure($sformatf(
                            "result %0d: read_value exp %0d got %0d, change_sum exp %0d got %0d",
                            delivered, want.read_value, m_read_value,
                            want.change_sum, m_change_sum));
                end
                delivered++;
            end
            if (s_valid && s_ready)
                results_due.push_back(predict_item(s_kind, s_row, s_col, s_cell_value));
        end
        outstanding <= results_due.size();
    end

endmodule

// ===== verif/jacobi_grid_sweep_test.sv =====
`timescale 1ns / 100ps
// Testbench top of the Jacobi grid sweep block: clock, reset, stimulus and verdict.
module jacobi_grid_sweep_test;
    import jgs_pkg::*;

    localparam int GRID_SIZE    = 64;
    localparam int LAST         = GRID_SIZE - 1;
    localparam int RANDOM_ITEMS = 100;
    localparam int PHASES       = 5;
    localparam int SETTLE       = 50;

    // The block ignores this kind; it still returns an all-zero item.
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam logic [DATA_W-1:0] VAL_MAX  = 16'h7FFF;
    localparam logic [DATA_W-1:0] VAL_MIN  = 16'h8000;
    localparam logic [DATA_W-1:0] VAL_NEG1 = 16'hFFFF;
    localparam logic [DATA_W-1:0] VAL_NEG2 = 16'hFFFE;
    localparam logic [DATA_W-1:0] VAL_LSB  = 16'h0001;

    // Every input of the block starts at a known value.
    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic [KIND_W-1:0]          s_kind       = KIND_WRITE;
    logic [ROWCOL_W-1:0]        s_row        = '0;
    logic [ROWCOL_W-1:0]        s_col        = '0;
    logic signed [DATA_W-1:0]   s_cell_value = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [DATA_W-1:0]   m_read_value;
    logic [SUM_W-1:0]           m_change_sum;
    logic                       cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = CFG_EDGE_TOP;
    logic [DATA_W-1:0]          cfg_wdata    = '0;

    int failures;
    int outstanding;

    // Stimulus bookkeeping: item counts for the phase lengths and the closing summary.
    int  n_write, n_read, n_sweep, n_spare;
    bit  no_idle = 1'b0;

    jacobi_grid_sweep #(
        .GRID_SIZE(GRID_SIZE)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_row(s_row),
        .s_col(s_col),
        .s_cell_value(s_cell_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_read_value(m_read_value),
        .m_change_sum(m_change_sum),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    // The checker watches both channels and the configuration port on its own.
    jacobi_grid_sweep_checker #(
        .GRID_SIZE(GRID_SIZE)
    ) sweep_check (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_row(s_row),
        .s_col(s_col),
        .s_cell_value(s_cell_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_read_value(m_read_value),
        .m_change_sum(m_change_sum),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .failures(failures),
        .outstanding(outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Gap lengths: mostly none or short, now and then long. During the
    // gap-free phase both sides run flat out.
    function automatic int gap_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Coordinates lean toward the border so that the edge values take part often.
    function automatic int pick_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return $urandom_range(0, 1);
        if (r < 4)
            return $urandom_range(LAST - 1, LAST);
        return $urandom_range(0, LAST);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return VAL_MAX;
        if (r == 1)
            return VAL_MIN;
        return DATA_W'($urandom);
    endfunction

    // The result side stalls in random bursts, except during the gap-free phase.
    initial begin : result_stall
        int n;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            n = gap_len();
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Presents one item and returns at the edge where it is accepted. Valid is
    // only lowered when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input logic [KIND_W-1:0] k, input int r, input int c,
                             input logic [DATA_W-1:0] v);
        int n;
        n = gap_len();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= k;
        s_row        <= ROWCOL_W'(r);
        s_col        <= ROWCOL_W'(c);
        s_cell_value <= v;
        do @(posedge aclk); while (!s_ready);
        case (k)
            KIND_WRITE: n_write++;
            KIND_SWEEP: n_sweep++;
            KIND_READ:  n_read++;
            default:    n_spare++;
        endcase
    endtask

    // Holds the sender off until every item accepted so far has been answered.
    // The checker's count is registered, so wait for an edge before looking.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    // Only called while no item is at work; the top, bottom, left and right edges are all written each time.
    task automatic load_edges(input logic [DATA_W-1:0] up, input logic [DATA_W-1:0] down,
                              input logic [DATA_W-1:0] lft, input logic [DATA_W-1:0] rgt);
        cfg_write(CFG_EDGE_TOP, up);
        cfg_write(CFG_EDGE_BOTTOM, down);
        cfg_write(CFG_EDGE_LEFT, lft);
        cfg_write(CFG_EDGE_RIGHT, rgt);
        cfg_we <= 1'b0;
    endtask

    // A well-formed probe: load a cell and its in-grid neighbours, sweep, and
    // read the same cells back from the new bank.
    task automatic probe_stencil();
        int r0, c0, rr, cc;
        r0 = pick_coord();
        c0 = pick_coord();
        for (int k = 0; k < 5; k++) begin
            rr = r0 + ((k == 1) ? -1 : (k == 2) ? 1 : 0);
            cc = c0 + ((k == 3) ? -1 : (k == 4) ? 1 : 0);
            if (rr >= 0 && rr <= LAST && cc >= 0 && cc <= LAST)
                send_item(KIND_WRITE, rr, cc, pick_value());
        end
        send_item(KIND_SWEEP, $urandom_range(0, LAST), $urandom_range(0, LAST), pick_value());
        for (int k = 0; k < 5; k++) begin
            rr = r0 + ((k == 1) ? -1 : (k == 2) ? 1 : 0);
            cc = c0 + ((k == 3) ? -1 : (k == 4) ? 1 : 0);
            if (rr >= 0 && rr <= LAST && cc >= 0 && cc <= LAST)
                send_item(KIND_READ, rr, cc, pick_value());
        end
    endtask

    // A single item of random kind; sweeps are kept rare since each one
    // walks the whole grid.
    task automatic noise_item();
        int r;
        logic [KIND_W-1:0] k;
        r = $urandom_range(0, 99);
        if (r < 45)
            k = KIND_WRITE;
        else if (r < 82)
            k = KIND_READ;
        else if (r < 90)
            k = KIND_SWEEP;
        else
            k = KIND_SPARE;
        send_item(k, $urandom_range(0, LAST), $urandom_range(0, LAST), pick_value());
    endtask

    initial begin : stimulus
        int base;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Edges at mixed extremes: largest above, smallest
        // below, zero on the left and minus one LSB on the right.
        load_edges(VAL_MAX, VAL_MIN, '0, VAL_NEG1);

        // Extreme values into the four corners, and a small negative pair
        // around cell (32,32) so that the quarter has to round toward minus infinity.
        send_item(KIND_WRITE, 0, 0, VAL_MAX);
        send_item(KIND_WRITE, LAST, LAST, VAL_MIN);
        send_item(KIND_WRITE, 0, LAST, VAL_NEG1);
        send_item(KIND_WRITE, LAST, 0, VAL_LSB);
        send_item(KIND_WRITE, 31, 32, VAL_NEG1);
        send_item(KIND_WRITE, 32, 31, VAL_NEG2);
        send_item(KIND_READ, 0, 0, '0);
        send_item(KIND_READ, LAST, LAST, '0);
        send_item(KIND_READ, 0, LAST, '0);
        send_item(KIND_READ, LAST, 0, '0);

        // The unused kind must leave the grid alone and answer with zeros.
        send_item(KIND_SPARE, LAST, LAST, VAL_MAX);
        send_item(KIND_READ, LAST, LAST, '0);

        // A cell that was only ever cleared by reset.
        send_item(KIND_READ, 20, 40, '0);

        // Sweeps, with reads in between to follow the bank swaps.
        send_item(KIND_SWEEP, 0, 0, '0);
        send_item(KIND_READ, 32, 32, '0);
        send_item(KIND_READ, 0, 0, '0);
        send_item(KIND_READ, LAST, LAST, '0);
        send_item(KIND_SWEEP, LAST, LAST, VAL_MAX);
        send_item(KIND_SWEEP, 0, 0, VAL_MIN);
        send_item(KIND_READ, 0, 1, '0);
        send_item(KIND_READ, LAST - 1, LAST, '0);
        send_item(KIND_WRITE, 0, 0, VAL_MIN);
        send_item(KIND_SWEEP, 0, 0, '0);
        send_item(KIND_READ, 0, 0, '0);

        // Random part in phases. Each phase starts from an idle block with a
        // new edge setting: all largest, all smallest, random, zero, random.
        // The middle phase runs with no gaps on either side.
        base = n_write + n_read + n_sweep;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                0: load_edges(VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
                1: load_edges(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
                3: load_edges('0, '0, '0, '0);
                default: load_edges(pick_value(), pick_value(), pick_value(), pick_value());
            endcase
            no_idle = (p == 2);
            while (n_write + n_read + n_sweep < base + RANDOM_ITEMS * (p + 1) / PHASES) begin
                if ($urandom_range(0, 99) < 55)
                    probe_stencil();
                else
                    noise_item();
                // Now and then the sender waits for the result side to catch up.
                if ($urandom_range(0, 19) == 0)
                    wait_drained();
            end
        end
        no_idle = 1'b0;

        // Drain, then give the block time to show any stray item.
        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d writes, %0d reads, %0d sweeps and %0d unused-kind items.",
                 n_write, n_read, n_sweep, n_spare);
        $display("Edges went through mixed, all-max, all-min, random and zero settings.");
        if (failures == 0 && outstanding == 0)
            $display("jacobi_grid_sweep_test: done, clean");
        else
            $display("jacobi_grid_sweep_test: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, clearing pass included.
    initial begin : watchdog
        #10_000_000;
        $display("Run stopped by watchdog with %0d items still expected.", outstanding);
        $display("jacobi_grid_sweep_test: done, errors");
        $finish;
    end

endmodule
